>>> rtl/cfmp_pkg.sv
// ----------------------------------------------------------------------------
// cfmp_pkg: shared definitions for the command frame to motor packet block
// Frame and packet constants, result status codes, the CRC-8 byte update and
// the command and status structs exchanged by the controller and datapath.
// ----------------------------------------------------------------------------
package cfmp_pkg;

  localparam int NUM_MOTORS = 8;
  localparam int FRAME_LEN  = 16;
  localparam int PKT_LEN    = 7;

  localparam int IDX_W = 4;
  localparam int MOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int POS_W = $clog2(PKT_LEN);

  localparam logic [7:0] START_BYTE = 8'h12;
  localparam logic [7:0] END_BYTE   = 8'h13;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] MAG_BAD    = 8'd18;
  localparam logic [7:0] MAG_SUB    = 8'd17;

  // Positions of the bytes within one motor packet.
  localparam logic [POS_W-1:0] POS_START = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DIR   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MAG   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CRC   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_END   = POS_W'(PKT_LEN - 1);

  typedef enum logic [1:0] {
    ST_PACKET = 2'd0,
    ST_REJECT = 2'd1,
    ST_ABORT  = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic             frame_start;
    logic             frame_byte;
    logic [IDX_W-1:0] idx;
    logic             emit;
    logic [MOT_W-1:0] motor;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             put_status;
    status_t          status;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_start;
    logic frame_ok;
    logic slot_free;
  } dp_stat_t;

  // Reflected CRC-8, one byte, LSB first.
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

>>> rtl/cfmp_ctrl.sv
// ----------------------------------------------------------------------------
// cfmp_ctrl: frame sequencing controller
// Tracks frame position, decides the fate of each frame and steps through
// the motor packet bytes of a valid frame.
// ----------------------------------------------------------------------------
module cfmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfmp_pkg::dp_stat_t  st,
  output cfmp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_WAIT,
    S_FRAME,
    S_EMIT
  } state_t;

  localparam logic [cfmp_pkg::IDX_W-1:0] LAST_IDX =
    cfmp_pkg::IDX_W'(cfmp_pkg::FRAME_LEN - 1);
  localparam logic [cfmp_pkg::MOT_W-1:0] LAST_MOT =
    cfmp_pkg::MOT_W'(cfmp_pkg::NUM_MOTORS - 1);

  state_t                       state_r, state_nxt;
  logic [cfmp_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [cfmp_pkg::MOT_W-1:0]   mot_r, mot_nxt;
  logic [cfmp_pkg::POS_W-1:0]   pos_r, pos_nxt;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    mot_nxt        = mot_r;
    pos_nxt        = pos_r;
    cmd            = '0;
    cmd.status     = cfmp_pkg::ST_PACKET;
    cmd.idx        = idx_r;
    cmd.motor      = mot_r;
    cmd.pos        = pos_r;
    in_stall       = 1'b1;
    case (state_r)
      S_WAIT: begin
        in_stall = !st.slot_free;
        if (in_valid && st.slot_free && st.is_start) begin
          cmd.frame_start = 1'b1;
          idx_nxt         = cfmp_pkg::IDX_W'(1);
          state_nxt       = S_FRAME;
        end
      end
      S_FRAME: begin
        in_stall = !st.slot_free;
        if (in_valid && st.slot_free) begin
          if (st.is_start) begin
            cmd.put_status = 1'b1;
            cmd.status     = cfmp_pkg::ST_ABORT;
            cmd.last       = 1'b1;
            idx_nxt        = '0;
            state_nxt      = S_WAIT;
          end else begin
            cmd.frame_byte = 1'b1;
            if (idx_r < LAST_IDX) begin
              idx_nxt = idx_r + cfmp_pkg::IDX_W'(1);
            end else begin
              idx_nxt = '0;
              if (st.frame_ok) begin
                mot_nxt   = '0;
                pos_nxt   = cfmp_pkg::POS_START;
                state_nxt = S_EMIT;
              end else begin
                cmd.put_status = 1'b1;
                cmd.status     = cfmp_pkg::ST_REJECT;
                cmd.last       = 1'b1;
                state_nxt      = S_WAIT;
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.last = (mot_r == LAST_MOT) && (pos_r == cfmp_pkg::POS_END);
          if (pos_r == cfmp_pkg::POS_END) begin
            pos_nxt = cfmp_pkg::POS_START;
            if (mot_r == LAST_MOT) begin
              state_nxt = S_WAIT;
            end else begin
              mot_nxt = mot_r + cfmp_pkg::MOT_W'(1);
            end
          end else begin
            pos_nxt = pos_r + cfmp_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      idx_r   <= '0;
      mot_r   <= '0;
      pos_r   <= cfmp_pkg::POS_START;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mot_r   <= mot_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

>>> rtl/cfmp_dp.sv
// ----------------------------------------------------------------------------
// cfmp_dp: frame and packet datapath
// Running CRC, stored motor commands, packet byte generation with its own
// CRC, and the output register.
// ----------------------------------------------------------------------------
module cfmp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_rx_byte,
  input  cfmp_pkg::ctrl_cmd_t cmd,
  output cfmp_pkg::dp_stat_t  st,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [1:0]          out_status
);

  localparam logic [cfmp_pkg::IDX_W-1:0] CRC_LAST_IDX =
    cfmp_pkg::IDX_W'(cfmp_pkg::FRAME_LEN - 3);
  localparam logic [cfmp_pkg::IDX_W-1:0] CHK_IDX =
    cfmp_pkg::IDX_W'(cfmp_pkg::FRAME_LEN - 2);
  localparam logic [cfmp_pkg::IDX_W-1:0] MOT_LAST_IDX =
    cfmp_pkg::IDX_W'(cfmp_pkg::NUM_MOTORS);

  logic [7:0]                 crc_r;
  logic                       match_r;
  logic [7:0]                 pcrc_r;
  logic [7:0]                 motor_r [cfmp_pkg::NUM_MOTORS];
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  cfmp_pkg::status_t          out_status_r;

  logic [cfmp_pkg::IDX_W-1:0] widx;
  logic [7:0]                 cmd_byte;
  logic [7:0]                 mag;
  logic [7:0]                 pkt_byte;
  logic                       slot_free;
  logic                       load;

  assign slot_free   = !out_valid_r || !out_stall;
  assign load        = cmd.emit || cmd.put_status;
  assign st.slot_free = slot_free;
  assign st.is_start = (in_rx_byte == cfmp_pkg::START_BYTE);
  assign st.frame_ok = match_r && (in_rx_byte == cfmp_pkg::END_BYTE);

  assign widx = cmd.idx - cfmp_pkg::IDX_W'(1);

  always_comb begin
    cmd_byte = motor_r[cmd.motor];
    mag      = {cmd_byte[6:0], 1'b0};
    if (mag == cfmp_pkg::MAG_BAD) begin
      mag = cfmp_pkg::MAG_SUB;
    end
    case (cmd.pos)
      cfmp_pkg::POS_START: pkt_byte = cfmp_pkg::START_BYTE;
      cfmp_pkg::POS_ADDR:  pkt_byte = 8'(cmd.motor) + 8'd1;
      cfmp_pkg::POS_ONE:   pkt_byte = 8'd1;
      cfmp_pkg::POS_DIR:   pkt_byte = {7'd0, ~cmd_byte[7]};
      cfmp_pkg::POS_MAG:   pkt_byte = mag;
      cfmp_pkg::POS_CRC:   pkt_byte = pcrc_r;
      default:             pkt_byte = cfmp_pkg::END_BYTE;
    endcase
  end

  // Frame collection and packet CRC; the CRCs and the match flag are cleared at the start of their use.
  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      crc_r   <= 8'd0;
      match_r <= 1'b0;
    end
    if (cmd.frame_byte) begin
      if (cmd.idx != '0 && cmd.idx <= MOT_LAST_IDX) begin
        motor_r[widx[cfmp_pkg::MOT_W-1:0]] <= in_rx_byte;
      end
      if (cmd.idx <= CRC_LAST_IDX) begin
        crc_r <= cfmp_pkg::crc8_add(crc_r, in_rx_byte);
      end
      if (cmd.idx == CHK_IDX) begin
        match_r <= (in_rx_byte == crc_r);
      end
    end
    if (cmd.emit) begin
      if (cmd.pos == cfmp_pkg::POS_START) begin
        pcrc_r <= 8'd0;
      end else if (cmd.pos <= cfmp_pkg::POS_MAG) begin
        pcrc_r <= cfmp_pkg::crc8_add(pcrc_r, pkt_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      out_byte_r   <= cmd.emit ? pkt_byte : 8'd0;
      out_last_r   <= cmd.last;
      out_status_r <= cmd.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

>>> rtl/command_frame_to_motor_packets_top.sv
// ----------------------------------------------------------------------------
// command_frame_to_motor_packets_top: command frame to motor packet translator
// Checks CRC-8 framed command frames and turns each valid one into a burst
// of motor packets.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_rx_byte) carries one received
// byte per transaction. Outside a frame every byte except the start byte is
// dropped. Frame bytes are taken one per cycle while the output register is
// free or draining.
// The output channel (out_valid, out_stall, out_byte, out_last, out_status)
// carries one result per transaction from a single output register. A status
// result is offered from the cycle after the byte that causes it; the first
// packet byte of a valid frame comes in the cycle after that.
// A valid frame yields NUM_MOTORS packets of seven bytes, one byte per cycle
// when the receiver does not stall, and the input is stalled for that whole
// burst. A rejected or aborted frame yields a single status transaction with
// last set. When the receiver stalls, the output register holds its result
// and the input stalls too, so nothing is lost. Synchronous reset returns the
// block to waiting for a start byte with the output register empty.
// ----------------------------------------------------------------------------
module command_frame_to_motor_packets_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  // Command and status groups between controller and datapath.
  cfmp_pkg::ctrl_cmd_t cmd;
  cfmp_pkg::dp_stat_t  st;

  // The controller owns frame position and packet sequencing.
  cfmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the CRCs, the stored commands and the output register.
  cfmp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

`ifndef NO_ASSERTIONS
  // No input byte is taken while a packet burst is being emitted.
  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> in_stall)
    else $error("input accepted during packet emission");

  // Status-only results carry a zero byte and end their burst.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cfmp_pkg::ST_PACKET) |-> (out_last && out_byte == 8'd0))
    else $error("malformed status result");

  // The final byte of a packet burst is the end byte.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_status == cfmp_pkg::ST_PACKET)
      |-> (out_byte == cfmp_pkg::END_BYTE))
    else $error("packet burst does not close with the end byte");

  // A result is only loaded when the output register can take it.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.put_status) |-> st.slot_free)
    else $error("result issued while output register is held");
`endif

endmodule

>>> bench/motor_packet_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_packet_checker: scoreboard for the command frame translator
// Watches both channels, predicts the motor packet bytes and status results
// for every accepted received byte, and compares them in order with the
// results that the block hands out.
// ----------------------------------------------------------------------------
module motor_packet_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         expected_left
);

  typedef struct {
    logic [7:0]        data;
    logic              last;
    cfmp_pkg::status_t status;
  } motor_result_t;

  motor_result_t pending_results[$];
  motor_result_t want;

  // Predicted frame state.
  logic       framing;
  logic [3:0] next_idx;
  logic [7:0] crc_acc;
  logic       crc_good;
  logic [7:0] cmd_store [cfmp_pkg::NUM_MOTORS];

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ data[i]) ? ((r >> 1) ^ cfmp_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_result(input logic [7:0] data, input logic last,
                             input cfmp_pkg::status_t status);
    motor_result_t item;
    item.data   = data;
    item.last   = last;
    item.status = status;
    pending_results.push_back(item);
  endtask

  // Works out the results that one received byte causes.
  task automatic translate_byte(input logic [7:0] b);
    logic [7:0] pkt [cfmp_pkg::PKT_LEN];
    logic [7:0] cmd;
    logic [7:0] mag;
    if (!framing) begin
      if (b == cfmp_pkg::START_BYTE) begin
        framing  = 1'b1;
        next_idx = 4'd1;
        crc_acc  = 8'h00;
        crc_good = 1'b0;
      end
    end else if (b == cfmp_pkg::START_BYTE) begin
      framing  = 1'b0;
      next_idx = 4'd0;
      push_result(8'h00, 1'b1, cfmp_pkg::ST_ABORT);
    end else begin
      if (next_idx >= 1 && next_idx <= cfmp_pkg::NUM_MOTORS) begin
        cmd_store[int'(next_idx) - 1] = b;
      end
      if (next_idx <= cfmp_pkg::FRAME_LEN - 3) begin
        crc_acc = crc8_step(crc_acc, b);
      end
      if (next_idx == cfmp_pkg::FRAME_LEN - 2) begin
        crc_good = (b == crc_acc);
      end
      if (next_idx < cfmp_pkg::FRAME_LEN - 1) begin
        next_idx = next_idx + 4'd1;
      end else begin
        framing  = 1'b0;
        next_idx = 4'd0;
        if (!(crc_good && b == cfmp_pkg::END_BYTE)) begin
          push_result(8'h00, 1'b1, cfmp_pkg::ST_REJECT);
        end else begin
          for (int m = 0; m < cfmp_pkg::NUM_MOTORS; m++) begin
            cmd = cmd_store[m];
            mag = {cmd[6:0], 1'b0};
            if (mag == cfmp_pkg::MAG_BAD) begin
              mag = cfmp_pkg::MAG_SUB;
            end
            pkt[0] = cfmp_pkg::START_BYTE;
            pkt[1] = 8'(m + 1);
            pkt[2] = 8'd1;
            pkt[3] = {7'd0, ~cmd[7]};
            pkt[4] = mag;
            pkt[5] = 8'h00;
            for (int j = 1; j <= 4; j++) begin
              pkt[5] = crc8_step(pkt[5], pkt[j]);
            end
            pkt[6] = cfmp_pkg::END_BYTE;
            for (int j = 0; j < cfmp_pkg::PKT_LEN; j++) begin
              push_result(pkt[j],
                          (m == cfmp_pkg::NUM_MOTORS - 1) && (j == cfmp_pkg::PKT_LEN - 1),
                          cfmp_pkg::ST_PACKET);
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      framing  = 1'b0;
      next_idx = 4'd0;
      crc_acc  = 8'h00;
      crc_good = 1'b0;
      pending_results.delete();
      fail_count = 0;
    end else begin
      // A result always belongs to a byte taken at an earlier edge, so it is
      // checked before this edge's byte adds its own expectations.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result byte %02h last %0d status %0d",
                     $realtime, out_byte, out_last, out_status);
          end
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.data || out_last !== want.last ||
              out_status !== want.status) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch, expected byte %02h last %0d status %0d,",
                       $realtime, want.data, want.last, want.status,
                       " got byte %02h last %0d status %0d",
                       out_byte, out_last, out_status);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        translate_byte(in_rx_byte);
      end
    end
    expected_left = pending_results.size();
  end

endmodule

>>> bench/command_frame_to_motor_packets_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_to_motor_packets_top_tb: testbench for the frame translator
// Feeds command frames (good, bad CRC, bad end byte, aborted) and line noise
// into the block under random idling and back-pressure, while a separate
// checker predicts every motor packet and status result and compares them.
// ----------------------------------------------------------------------------
module command_frame_to_motor_packets_top_tb;

  // Longest run of cycles with no transaction on either channel before the
  // run is declared hung. The long receiver hold-off below stays well under.
  localparam int QUIET_LIMIT     = 4000;
  localparam int LONG_HOLD       = 400;
  localparam int ITEMS_PER_PHASE = 80;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_END,
    FR_ABORT
  } frame_kind_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] out_status;

  int fail_count;
  int expected_left;

  // Idling controls, in percent, set per phase by the stimulus.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_send [4] = '{0, 88, 0, 23};
  int idle_recv [4] = '{0, 0, 88, 23};

  int items_sent = 0;
  int hold_reqs  = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int quiet      = 0;

  logic [7:0] motor_cmd [cfmp_pkg::NUM_MOTORS];

  always #4 clk = ~clk;

  command_frame_to_motor_packets_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_status(out_status)
  );

  motor_packet_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  // Receiver. A hold-off request from the stimulus makes it stall for a long
  // stretch, counted here, so the block fills up and stalls its input while
  // the sender keeps offering bytes. Otherwise it stalls at random.
  always @(negedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken = hold_reqs;
      hold_left  = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Any byte except the start byte. Used for frame content, which must not
  // hold a start byte unless the frame is meant to abort, and for line noise.
  function automatic logic [7:0] any_but_start();
    logic [7:0] v;
    do begin
      v = 8'($urandom_range(255));
    end while (v == cfmp_pkg::START_BYTE);
    return v;
  endfunction

  // Motor commands lean toward the interesting values: the magnitude that is
  // remapped (low seven bits 9), both ends of each direction, and zero.
  task automatic random_commands();
    for (int i = 0; i < cfmp_pkg::NUM_MOTORS; i++) begin
      case ($urandom_range(5))
        0:       motor_cmd[i] = $urandom_range(1) ? 8'h89 : 8'h09;
        1:       motor_cmd[i] = $urandom_range(1) ? 8'h00 : 8'hFF;
        2:       motor_cmd[i] = $urandom_range(1) ? 8'h7F : 8'h80;
        default: motor_cmd[i] = any_but_start();
      endcase
    end
  endtask

  // Offers one byte and returns at the falling edge after it is taken. The
  // valid line is only touched once per edge, so it stays high across
  // back-to-back transactions. Noise bytes outside a frame are not counted.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    if (counted) begin
      items_sent++;
    end
  endtask

  // Stops offering and waits until every predicted result has come out. At
  // least one falling edge passes, so valid is never driven twice at once.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (expected_left != 0);
  endtask

  // Builds a frame around the current motor commands and sends it. The CRC
  // byte is redrawn content-wise when it would itself be a start byte, since
  // that would turn a good frame into an aborted one. cut_at picks where an
  // aborted frame gets its second start byte; zero means anywhere.
  task automatic send_frame(input frame_kind_t kind, input int cut_at);
    logic [7:0] body [cfmp_pkg::FRAME_LEN];
    logic [7:0] crc;
    int stop;
    body[0] = cfmp_pkg::START_BYTE;
    for (int i = 0; i < cfmp_pkg::NUM_MOTORS; i++) begin
      body[i + 1] = motor_cmd[i];
    end
    for (int i = cfmp_pkg::NUM_MOTORS + 1; i < cfmp_pkg::FRAME_LEN - 2; i++) begin
      body[i] = any_but_start();
    end
    do begin
      crc = 8'h00;
      for (int i = 1; i < cfmp_pkg::FRAME_LEN - 2; i++) begin
        crc = cfmp_pkg::crc8_add(crc, body[i]);
      end
      if (crc == cfmp_pkg::START_BYTE) begin
        body[cfmp_pkg::FRAME_LEN - 3] = any_but_start();
      end
    end while (crc == cfmp_pkg::START_BYTE);
    body[cfmp_pkg::FRAME_LEN - 2] = crc;
    body[cfmp_pkg::FRAME_LEN - 1] = cfmp_pkg::END_BYTE;
    stop = cfmp_pkg::FRAME_LEN - 1;
    case (kind)
      FR_BAD_CRC: begin
        do begin
          body[cfmp_pkg::FRAME_LEN - 2] = any_but_start();
        end while (body[cfmp_pkg::FRAME_LEN - 2] == crc);
      end
      FR_BAD_END: begin
        do begin
          body[cfmp_pkg::FRAME_LEN - 1] = any_but_start();
        end while (body[cfmp_pkg::FRAME_LEN - 1] == cfmp_pkg::END_BYTE);
        // Half of these also carry a wrong CRC.
        if ($urandom_range(1)) begin
          do begin
            body[cfmp_pkg::FRAME_LEN - 2] = any_but_start();
          end while (body[cfmp_pkg::FRAME_LEN - 2] == crc);
        end
      end
      FR_ABORT: begin
        stop = (cut_at > 0) ? cut_at : $urandom_range(1, cfmp_pkg::FRAME_LEN - 1);
        body[stop] = cfmp_pkg::START_BYTE;
      end
      default: begin
      end
    endcase
    for (int i = 0; i <= stop; i++) begin
      send_byte(body[i], 1'b1);
    end
  endtask

  initial begin
    int pick;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling: noise at both byte extremes while waiting,
    // a good frame with extreme and remapped commands, an abort on the very
    // first frame byte, and a frame with a wrong CRC.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    motor_cmd = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h09, 8'h89, 8'h01, 8'hFE};
    send_frame(FR_GOOD, 0);
    send_frame(FR_ABORT, 1);
    send_frame(FR_BAD_CRC, 0);

    // Long receiver hold-off while two good frames are offered behind it.
    hold_reqs++;
    random_commands();
    send_frame(FR_GOOD, 0);
    random_commands();
    send_frame(FR_GOOD, 0);

    // Random part, one phase per idling pattern. Mostly good frames so that
    // packet bursts dominate, with broken frames and noise mixed in.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_send[ph];
      stall_pct     = idle_recv[ph];
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3)) send_byte(any_but_start(), 1'b0);
        end
        random_commands();
        pick = $urandom_range(99);
        if (pick < 65) begin
          send_frame(FR_GOOD, 0);
        end else if (pick < 77) begin
          send_frame(FR_BAD_CRC, 0);
        end else if (pick < 87) begin
          send_frame(FR_BAD_END, 0);
        end else begin
          send_frame(FR_ABORT, 0);
        end
        if ($urandom_range(99) < 10) begin
          drain();
        end
      end
      drain();
    end

    // Everything predicted has arrived; keep watching the output in case the
    // block puts out anything extra.
    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cfmp_pkg.sv
rtl/cfmp_ctrl.sv
rtl/cfmp_dp.sv
rtl/command_frame_to_motor_packets_top.sv
bench/motor_packet_checker.sv
bench/command_frame_to_motor_packets_top_tb.sv
